// ----- sv/buddy_block_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Buddy allocator assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- sv/bba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared command/flag types, status codes and a bit-length helper function.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ORD_W = 5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXHAUST = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_SCAN_INC,
        OP_SPLIT_RD,
        OP_SPLIT_POP,
        OP_SPLIT_PUSH,
        OP_TAKE_RD,
        OP_TAKE,
        OP_EXHAUST,
        OP_BADFREE,
        OP_FREE_RD,
        OP_FREE_MARK,
        OP_BUDDY_RD,
        OP_WALK_INIT,
        OP_WALK_RD,
        OP_WALK_NEXT,
        OP_WALK_FIX,
        OP_MERGE_LO,
        OP_MERGE_HI,
        OP_PUSH,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_free;
        logic cm_over;
        logic head_empty;
        logic cm_gt_m;
        logic bad_off;
        logic bad_meta;
        logic at_max;
        logic buddy_ok;
        logic walk_end;
        logic walk_hit;
        logic out_free;
    } flags_t;

    function automatic logic [5:0] bit_len(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- sv/bba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences clear pass, allocate split walk, free merge walk and output load.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    input  flags_t flags,
    output cmd_t   cmd
);

    typedef enum logic [15:0] {
        S_CLEAR       = 16'h0001,
        S_IDLE        = 16'h0002,
        S_ASCAN       = 16'h0004,
        S_ASPLIT_POP  = 16'h0008,
        S_ASPLIT_PUSH = 16'h0010,
        S_ATAKE       = 16'h0020,
        S_FCHK        = 16'h0040,
        S_FMETA       = 16'h0080,
        S_FTEST       = 16'h0100,
        S_FBCHK       = 16'h0200,
        S_FWALK       = 16'h0400,
        S_FWALK_NEXT  = 16'h0800,
        S_FWALK_FIX   = 16'h1000,
        S_FMERGE_LO   = 16'h2000,
        S_FMERGE_HI   = 16'h4000,
        S_DONE        = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (flags.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = flags.in_free ? S_FCHK : S_ASCAN;
                end
            end
            S_ASCAN: begin
                if (flags.cm_over) begin
                    cmd.op     = OP_EXHAUST;
                    state_next = S_DONE;
                end else if (flags.head_empty) begin
                    cmd.op = OP_SCAN_INC;
                end else if (flags.cm_gt_m) begin
                    cmd.op     = OP_SPLIT_RD;
                    state_next = S_ASPLIT_POP;
                end else begin
                    cmd.op     = OP_TAKE_RD;
                    state_next = S_ATAKE;
                end
            end
            S_ASPLIT_POP: begin
                cmd.op     = OP_SPLIT_POP;
                state_next = S_ASPLIT_PUSH;
            end
            S_ASPLIT_PUSH: begin
                cmd.op     = OP_SPLIT_PUSH;
                state_next = S_ASCAN;
            end
            S_ATAKE: begin
                cmd.op     = OP_TAKE;
                state_next = S_DONE;
            end
            S_FCHK: begin
                if (flags.bad_off) begin
                    cmd.op     = OP_BADFREE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_FREE_RD;
                    state_next = S_FMETA;
                end
            end
            S_FMETA: begin
                if (flags.bad_meta) begin
                    cmd.op     = OP_BADFREE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_FREE_MARK;
                    state_next = S_FTEST;
                end
            end
            S_FTEST: begin
                if (flags.at_max) begin
                    cmd.op     = OP_PUSH;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_BUDDY_RD;
                    state_next = S_FBCHK;
                end
            end
            S_FBCHK: begin
                if (!flags.buddy_ok) begin
                    cmd.op     = OP_PUSH;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_WALK_INIT;
                    state_next = S_FWALK;
                end
            end
            S_FWALK: begin
                if (flags.walk_end) begin
                    cmd.op     = OP_MERGE_LO;
                    state_next = S_FMERGE_HI;
                end else if (flags.walk_hit) begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_FWALK_FIX;
                end else begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_FWALK_NEXT;
                end
            end
            S_FWALK_NEXT: begin
                cmd.op     = OP_WALK_NEXT;
                state_next = S_FWALK;
            end
            S_FWALK_FIX: begin
                cmd.op     = OP_WALK_FIX;
                state_next = S_FMERGE_LO;
            end
            S_FMERGE_LO: begin
                cmd.op     = OP_MERGE_LO;
                state_next = S_FMERGE_HI;
            end
            S_FMERGE_HI: begin
                cmd.op     = OP_MERGE_HI;
                state_next = S_FTEST;
            end
            S_DONE: begin
                if (flags.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/bba_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Granule order/used RAM, link RAM, list heads, walk registers, output stage.
// ----------------------------------------------------------------------------
module bba_dpath
    import bba_pkg::*;
#(
    parameter int MIN_ORDER = 8,
    parameter int MAX_ORDER = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output flags_t      flags,
    input  logic [0:0]  s_tuser,
    input  logic [47:0] s_tdata,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [1:0]  m_tuser,
    output logic [23:0] m_tdata
);

    localparam int GW    = MAX_ORDER - MIN_ORDER;
    localparam int LW    = GW + 1;
    localparam int NGRAN = 1 << GW;
    localparam int HW    = $clog2(MAX_ORDER + 1);
    localparam int MW    = ORD_W + 1;

    localparam logic [LW-1:0]    NONE  = LW'(NGRAN);
    localparam logic [ORD_W-1:0] MAXO  = ORD_W'(MAX_ORDER);
    localparam logic [ORD_W-1:0] MINO  = ORD_W'(MIN_ORDER);
    localparam logic [31:0]      GMASK = (32'd1 << MIN_ORDER) - 32'd1;

    logic [LW-1:0]    heads_reg [MAX_ORDER+1];
    logic [GW-1:0]    clr_reg;
    logic             out_valid_reg;
    logic [1:0]       out_st_reg;
    logic [15:0]      out_off_reg;
    logic [ORD_W-1:0] out_ord_reg;

    logic [ORD_W-1:0] cm_reg, m_reg;
    logic [GW-1:0]    g_reg, b_reg;
    logic [LW-1:0]    cur_reg, prev_reg, steps_reg;
    logic [15:0]      off_reg;
    logic [1:0]       res_st_reg;
    logic [15:0]      res_off_reg;
    logic [ORD_W-1:0] res_ord_reg;

    logic [HW-1:0]    hsel;
    logic [LW-1:0]    head_rd;
    logic [ORD_W-1:0] cm_m1;
    logic [GW-1:0]    half, bud, lo, hi, og;
    logic [31:0]      off32, g32;
    logic [15:0]      g_off;
    logic [5:0]       blen;
    logic             req_over;
    logic [ORD_W-1:0] req_ord;

    logic             meta_we;
    logic [GW-1:0]    meta_wa, meta_ra;
    logic [MW-1:0]    meta_wd, meta_rd;
    logic             link_we;
    logic [GW-1:0]    link_wa, link_ra;
    logic [LW-1:0]    link_wd, link_rd;

    bba_ram #(.WIDTH(MW), .DEPTH(NGRAN)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_wa),
        .wdata (meta_wd),
        .raddr (meta_ra),
        .rdata (meta_rd)
    );

    bba_ram #(.WIDTH(LW), .DEPTH(NGRAN)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_wa),
        .wdata (link_wd),
        .raddr (link_ra),
        .rdata (link_rd)
    );

    assign cm_m1    = cm_reg - ORD_W'(1);
    assign half     = GW'(1) << (cm_m1 - MINO);
    assign bud      = g_reg ^ (GW'(1) << (m_reg - MINO));
    assign lo       = (g_reg < b_reg) ? g_reg : b_reg;
    assign hi       = (g_reg < b_reg) ? b_reg : g_reg;
    assign off32    = {16'd0, off_reg};
    assign og       = GW'(off32 >> MIN_ORDER);
    assign g32      = 32'(g_reg);
    assign g_off    = 16'(g32 << MIN_ORDER);
    assign blen     = bit_len(s_tdata[31:0]);
    assign req_over = blen > 6'(MAX_ORDER);
    assign req_ord  = (blen < 6'(MIN_ORDER)) ? MINO : blen[ORD_W-1:0];

    always_comb begin
        case (cmd.op) inside
            OP_SPLIT_POP:                       hsel = HW'(cm_m1);
            OP_WALK_INIT, OP_PUSH, OP_WALK_FIX: hsel = HW'(m_reg);
            default:                            hsel = HW'(cm_reg);
        endcase
    end

    assign head_rd = heads_reg[hsel];

    always_comb begin
        meta_we = 1'b0;
        meta_wa = g_reg;
        meta_wd = '0;
        meta_ra = g_reg;
        link_we = 1'b0;
        link_wa = g_reg;
        link_wd = head_rd;
        link_ra = cur_reg[GW-1:0];
        case (cmd.op) inside
            OP_CLEAR: begin
                meta_we = 1'b1;
                meta_wa = clr_reg;
                meta_wd = (clr_reg == '0) ? {1'b0, MAXO} : '0;
                link_we = 1'b1;
                link_wa = '0;
                link_wd = NONE;
            end
            OP_SPLIT_RD, OP_TAKE_RD: begin
                link_ra = head_rd[GW-1:0];
            end
            OP_SPLIT_POP: begin
                meta_we = 1'b1;
                meta_wd = {1'b0, cm_m1};
                link_we = 1'b1;
                link_wa = g_reg | half;
                link_wd = head_rd;
            end
            OP_SPLIT_PUSH: begin
                meta_we = 1'b1;
                meta_wa = g_reg | half;
                meta_wd = {1'b0, cm_m1};
                link_we = 1'b1;
                link_wd = {1'b0, g_reg | half};
            end
            OP_TAKE: begin
                meta_we = 1'b1;
                meta_wd = {1'b1, m_reg};
            end
            OP_FREE_RD: begin
                meta_ra = og;
            end
            OP_FREE_MARK: begin
                meta_we = 1'b1;
                meta_wd = {1'b0, meta_rd[ORD_W-1:0]};
            end
            OP_BUDDY_RD: begin
                meta_ra = bud;
            end
            OP_WALK_FIX: begin
                link_we = (prev_reg != NONE);
                link_wa = prev_reg[GW-1:0];
                link_wd = link_rd;
            end
            OP_MERGE_LO: begin
                meta_we = 1'b1;
                meta_wa = lo;
                meta_wd = {1'b0, m_reg + ORD_W'(1)};
            end
            OP_MERGE_HI: begin
                meta_we = 1'b1;
                meta_wa = b_reg;
            end
            OP_PUSH: begin
                link_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control state: list heads, clear counter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= MAX_ORDER; i++) begin
                heads_reg[i] <= (i == MAX_ORDER) ? '0 : NONE;
            end
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_CLEAR:      clr_reg <= clr_reg + GW'(1);
                OP_SPLIT_POP:  heads_reg[HW'(cm_reg)] <= link_rd;
                OP_SPLIT_PUSH: heads_reg[HW'(cm_m1)] <= {1'b0, g_reg};
                OP_TAKE:       heads_reg[HW'(m_reg)] <= link_rd;
                OP_WALK_FIX: begin
                    if (prev_reg == NONE) begin
                        heads_reg[HW'(m_reg)] <= link_rd;
                    end
                end
                OP_PUSH:       heads_reg[HW'(m_reg)] <= {1'b0, g_reg};
                default: begin
                end
            endcase
            if (cmd.op == OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                off_reg <= s_tdata[47:32];
                m_reg   <= req_ord;
                cm_reg  <= req_over ? ORD_W'(MAX_ORDER + 1) : req_ord;
            end
            OP_SCAN_INC:   cm_reg <= cm_reg + ORD_W'(1);
            OP_SPLIT_RD:   g_reg  <= head_rd[GW-1:0];
            OP_SPLIT_PUSH: cm_reg <= cm_m1;
            OP_TAKE_RD:    g_reg  <= head_rd[GW-1:0];
            OP_TAKE: begin
                res_st_reg  <= ST_OK;
                res_off_reg <= g_off;
                res_ord_reg <= m_reg;
            end
            OP_EXHAUST: begin
                res_st_reg  <= ST_EXHAUST;
                res_off_reg <= '0;
                res_ord_reg <= '0;
            end
            OP_BADFREE: begin
                res_st_reg  <= ST_BADFREE;
                res_off_reg <= '0;
                res_ord_reg <= '0;
            end
            OP_FREE_RD:   g_reg <= og;
            OP_FREE_MARK: m_reg <= meta_rd[ORD_W-1:0];
            OP_BUDDY_RD:  b_reg <= bud;
            OP_WALK_INIT: begin
                cur_reg   <= head_rd;
                prev_reg  <= NONE;
                steps_reg <= '0;
            end
            OP_WALK_NEXT: begin
                prev_reg  <= cur_reg;
                cur_reg   <= link_rd;
                steps_reg <= steps_reg + LW'(1);
            end
            OP_MERGE_LO: begin
                g_reg <= lo;
                b_reg <= hi;
            end
            OP_MERGE_HI: m_reg <= m_reg + ORD_W'(1);
            OP_PUSH: begin
                res_st_reg  <= ST_OK;
                res_off_reg <= g_off;
                res_ord_reg <= m_reg;
            end
            OP_EMIT: begin
                out_st_reg  <= res_st_reg;
                out_off_reg <= res_off_reg;
                out_ord_reg <= res_ord_reg;
            end
            default: begin
            end
        endcase
    end

    assign flags.clr_last   = (clr_reg == '1);
    assign flags.in_free    = s_tuser[0];
    assign flags.cm_over    = (cm_reg > MAXO);
    assign flags.head_empty = (head_rd == NONE);
    assign flags.cm_gt_m    = (cm_reg > m_reg);
    assign flags.bad_off    = ((off32 >> MAX_ORDER) != 32'd0) || ((off32 & GMASK) != 32'd0);
    assign flags.bad_meta   = !meta_rd[ORD_W] || (meta_rd[ORD_W-1:0] < MINO)
                              || (meta_rd[ORD_W-1:0] > MAXO);
    assign flags.at_max     = (m_reg == MAXO);
    assign flags.buddy_ok   = !meta_rd[ORD_W] && (meta_rd[ORD_W-1:0] == m_reg);
    assign flags.walk_end   = (steps_reg == NONE) || (cur_reg >= NONE);
    assign flags.walk_hit   = (cur_reg == {1'b0, b_reg});
    assign flags.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = {3'b000, out_ord_reg, out_off_reg};

endmodule

// ----- sv/buddy_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a heap tracked in granules.
//
//  channel  | direction | tdata / tuser
//  s_       | in        | tdata: request_bytes[31:0], free_offset[47:32]; tuser: action
//  m_       | out       | tdata: block_offset[15:0], granted_order[20:16]; tuser: status
//
// After reset a clear pass initializes the
// granule RAMs; s_tready stays low meanwhile.
// One transfer at a time, accept through output load: allocate scans up past
// empty orders, splits down to the requested order and takes the block; free
// checks offset and metadata, then merges while the buddy is free (unlinked by
// a list walk), up to the whole heap. A finished result waits in the output
// register; m_tready low stalls only the final load.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_unit_macros.svh"

module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MIN_ORDER = 8,
    parameter int MAX_ORDER = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_bytes, free_offset
    input  logic [0:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // block_offset, granted_order
    output logic [1:0]  m_tuser    // status
);

    cmd_t   cmd;
    flags_t flags;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .flags    (flags),
        .cmd      (cmd)
    );

    bba_dpath #(
        .MIN_ORDER (MIN_ORDER),
        .MAX_ORDER (MAX_ORDER)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .flags    (flags),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    assign s_tready = cmd.in_ready;

    `BBA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready,
                     "second transfer taken while busy")
    `BBA_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK),
                     m_tdata == 24'd0, "error result carries data")
    `BBA_ASSERT_IMPL(a_ok_order, aclk, aresetn, m_tvalid && (m_tuser == ST_OK),
                     (m_tdata[20:16] >= 5'(MIN_ORDER)) && (m_tdata[20:16] <= 5'(MAX_ORDER)),
                     "granted order out of range")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free requests with random gaps and output stalls, keeps
// its own model of the granule tables and free lists, and compares every
// result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
    import bba_pkg::*;

    localparam int MINO  = 8;
    localparam int MAXO  = 16;
    localparam int NG    = 1 << (MAXO - MINO);
    localparam int NONE  = NG;
    localparam bit ACT_ALLOC = 1'b0;
    localparam bit ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] offset;
        logic [4:0]  order;
    } grant_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    buddy_block_allocator_unit uut (.*);

    logic [4:0] gran_order [NG];
    bit         gran_used  [NG];
    int         gran_next  [NG];
    int         free_head  [MAXO + 1];
    int         live_blocks[$];
    grant_t     grants_due [$];
    int         errors;
    bit         idle_en;
    bit         hold_rx;
    int         hold_cycles = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end

    function automatic int bits_of(logic [31:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 32; i++) if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i < NG; i++) begin
            gran_order[i] = '0;
            gran_used[i] = 0;
            gran_next[i] = 0;
        end
        for (int i = 0; i <= MAXO; i++) free_head[i] = NONE;
        gran_order[0] = 5'(MAXO);
        gran_next[0] = NONE;
        free_head[MAXO] = 0;
    endfunction

    function automatic void list_remove(int m, int g);
        int prev, cur;
        prev = NONE;
        cur = free_head[m];
        for (int s = 0; s < NG && cur < NG; s++) begin
            if (cur == g) begin
                if (prev == NONE) free_head[m] = gran_next[cur];
                else gran_next[prev] = gran_next[cur];
                return;
            end
            prev = cur;
            cur = gran_next[cur];
        end
    endfunction

    function automatic grant_t heap_apply(bit act, logic [31:0] nbytes, logic [15:0] off);
        grant_t r;
        int m, cm, g, h, b;
        r = '{status: ST_OK, offset: '0, order: '0};
        if (act == ACT_ALLOC) begin
            m = bits_of(nbytes);
            if (m < MINO) m = MINO;
            if (m > MAXO) begin
                r.status = ST_EXHAUST;
                return r;
            end
            cm = m;
            while (cm <= MAXO && free_head[cm] == NONE) cm++;
            if (cm > MAXO) begin
                r.status = ST_EXHAUST;
                return r;
            end
            while (cm > m) begin
                g = free_head[cm];
                free_head[cm] = gran_next[g];
                h = g + (1 << (cm - 1 - MINO));
                gran_order[g] = 5'(cm - 1);
                gran_order[h] = 5'(cm - 1);
                gran_next[h] = free_head[cm - 1];
                free_head[cm - 1] = h;
                gran_next[g] = h;
                free_head[cm - 1] = g;
                cm--;
            end
            g = free_head[m];
            free_head[m] = gran_next[g];
            gran_used[g] = 1;
            live_blocks.push_back(g << MINO);
            r.offset = 16'(g << MINO);
            r.order = 5'(m);
            return r;
        end
        if (off[7:0] != 0) begin
            r.status = ST_BADFREE;
            return r;
        end
        g = int'(off >> MINO);
        m = int'(gran_order[g]);
        if (!gran_used[g] || m < MINO || m > MAXO) begin
            r.status = ST_BADFREE;
            return r;
        end
        gran_used[g] = 0;
        foreach (live_blocks[i]) if (live_blocks[i] == int'(off)) begin
            live_blocks.delete(i);
            break;
        end
        while (m < MAXO) begin
            b = g ^ (1 << (m - MINO));
            if (gran_used[b] || int'(gran_order[b]) != m) break;
            list_remove(m, b);
            if (g > b) begin
                h = g;
                g = b;
                b = h;
            end
            gran_order[g] = 5'(m + 1);
            gran_order[b] = '0;
            m++;
        end
        gran_next[g] = free_head[m];
        free_head[m] = g;
        r.offset = 16'(g << MINO);
        r.order = 5'(m);
        return r;
    endfunction

    task automatic send_request(bit act, logic [31:0] nbytes, logic [15:0] off);
        if (idle_en && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (idle_en && $urandom_range(99) < 30);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {off, nbytes};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        grants_due.push_back(heap_apply(act, nbytes, off));
    endtask

    task automatic send_alloc(logic [31:0] nbytes);
        send_request(ACT_ALLOC, nbytes, 16'($urandom));
    endtask

    task automatic send_free(logic [15:0] off);
        send_request(ACT_FREE, $urandom, off);
    endtask

    task automatic free_all();
        while (live_blocks.size() > 0)
            send_free(16'(live_blocks[$urandom_range(live_blocks.size() - 1)]));
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (grants_due.size() > 0 && n < 100000) begin
            @(posedge aclk);
            n++;
        end
        repeat (200) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (grants_due.size() == 0) begin
                $display("%0t unexpected transfer status=%0d offset=%h order=%0d",
                         $realtime, m_tuser, m_tdata[15:0], m_tdata[20:16]);
                errors++;
            end else begin
                want = grants_due.pop_front();
                if (m_tuser != want.status || m_tdata[15:0] != want.offset
                        || m_tdata[20:16] != want.order || m_tdata[23:21] != 0) begin
                    $display("%0t mismatch expected %0d/%h/%0d actual %0d/%h/%0d",
                             $realtime, want.status, want.offset, want.order,
                             m_tuser, m_tdata[15:0], m_tdata[20:16]);
                    errors++;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_rx) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            m_tready <= !(idle_en && $urandom_range(99) < 30);
        end
    end

    task automatic test_directed();
        send_alloc(0);
        send_alloc(256);
        send_alloc(255);
        send_alloc(32'hFFFF_FFFF);
        send_alloc(32'h0001_0000);
        send_alloc(32'h0000_8000);
        send_free(16'h0001);
        send_free(16'hFF00);
        send_free(16'h0080);
        free_all();
        send_free(16'h0000);
        send_alloc(32'h0000_FFFF);
        send_alloc(1);
        free_all();
        for (int i = 0; i < 6; i++) send_alloc(200);
        free_all();
        send_free(16'hFFFF);
    endtask

    task automatic test_random(int count);
        int k, sz;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 45) begin
                sz = $urandom_range(16, 1);
                send_alloc($urandom_range(1 << sz, 1 << (sz - 1)) - $urandom_range(1));
            end else if (k < 48) begin
                send_alloc($urandom);
            end else if (k < 88 && live_blocks.size() > 0) begin
                send_free(16'(live_blocks[$urandom_range(live_blocks.size() - 1)]));
            end else begin
                send_free(16'($urandom));
            end
        end
    endtask

    task automatic test_fill_heap();
        for (int i = 0; i < 260; i++) send_alloc($urandom_range(256));
        free_all();
    endtask

    task automatic test_output_stall();
        fork
            begin
                hold_rx = 1;
                while (hold_cycles < 2000) @(posedge aclk);
                hold_rx = 0;
            end
            for (int i = 0; i < 12; i++) send_alloc($urandom_range(4096));
        join
        drain();
    endtask

    initial begin
        errors = 0;
        idle_en = 1;
        hold_rx = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        heap_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(700);
        idle_en = 0;
        test_random(300);
        idle_en = 1;
        test_output_stall();
        test_fill_heap();
        test_random(500);
        drain();
        if (errors == 0 && grants_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_ctrl.sv
sv/bba_dpath.sv
sv/buddy_block_allocator_unit.sv
verif/tb.sv
